// ===== rtl/sme_pkg.sv =====
// Package for the stack machine executor: sizes, opcodes, status codes, states, iterative unit types and saturation.
package sme_pkg;

   localparam int DataDepth   = 64;
   localparam int ReturnDepth = 16;
   localparam int NumRegs     = 4;
   localparam int DataAw      = $clog2(DataDepth);
   localparam int RetAw       = $clog2(ReturnDepth);
   localparam int DataCw      = $clog2(DataDepth + 1);
   localparam int RetCw       = $clog2(ReturnDepth + 1);

   typedef enum logic [4:0] {
      OP_HLT = 5'd0, OP_PUSHIMM = 5'd1, OP_PUSHREG = 5'd2, OP_DROP = 5'd3,
      OP_POPREG = 5'd4, OP_ADD = 5'd5, OP_SUB = 5'd6, OP_MUL = 5'd7,
      OP_DIV = 5'd8, OP_SQRT = 5'd9, OP_OUT = 5'd10, OP_IN = 5'd11,
      OP_CMP = 5'd12, OP_JMP = 5'd13, OP_CALL = 5'd14, OP_RET = 5'd15,
      OP_JE = 5'd16, OP_JNE = 5'd17, OP_JA = 5'd18, OP_JAE = 5'd19,
      OP_JB = 5'd20, OP_JBE = 5'd21, OP_NOP = 5'd22
   } op_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_UNDERFLOW = 3'd1, ST_DATA_OVF = 3'd2, ST_RET_OVF = 3'd3,
      ST_DIV_ZERO = 3'd4, ST_SQRT_NEG = 3'd5, ST_OUT_EMPTY = 3'd6,
      ST_ILLEGAL = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_EXEC, S_ITER, S_DONE
   } state_type;

   typedef enum logic [1:0] {
      IT_MUL, IT_DIV, IT_SQRT
   } iter_op_type;

   // start request to the iterative unit
   typedef struct packed {
      logic        start;
      iter_op_type op;
      logic [31:0] a;
      logic [31:0] b;
   } iter_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] result;
   } iter_rsp_type;

   function automatic logic [31:0] sat_q(input logic signed [65:0] v);
      logic [31:0] r;
      if (v > 66'sh7FFFFFFF) r = 32'h7FFFFFFF;
      else if (v < -66'sh80000000) r = 32'h80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

// ===== rtl/sme_iter.sv =====
// Iterative multiply, divide and square root unit on Q16.16 operands.
module sme_iter (
   input  logic                  clock,
   input  logic                  reset,
   input  sme_pkg::iter_req_type req,
   output sme_pkg::iter_rsp_type rsp
);
   import sme_pkg::*;

   // mul: 4 partial products of 16x16 bits, one a cycle
   // div: 48-bit restoring divide, one quotient bit a cycle
   // sqrt: 48-bit radicand, one result bit a cycle
   logic              busy_ff, busy_in;
   iter_op_type       op_ff, op_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic              neg_ff, neg_in;
   logic [63:0]       acc_ff, acc_in;   // mul product / div quotient / sqrt root
   logic [63:0]       rem_ff, rem_in;   // remainder
   logic [47:0]       num_ff, num_in;   // dividend / radicand bits left
   logic [31:0]       ua_ff, ua_in, ub_ff, ub_in;
   logic              done_ff, done_in;
   logic [31:0]       res_ff, res_in;

   logic [31:0]       abs_a, abs_b;
   logic [15:0]       pa, pb;
   logic [31:0]       pp;
   logic [63:0]       trial;
   logic [63:0]       sq_rem, sq_trial;
   logic signed [65:0] sv;

   assign abs_a = req.a[31] ? (~req.a + 32'd1) : req.a;
   assign abs_b = req.b[31] ? (~req.b + 32'd1) : req.b;
   assign pa = cnt_ff[1] ? ua_ff[31:16] : ua_ff[15:0];
   assign pb = cnt_ff[0] ? ub_ff[31:16] : ub_ff[15:0];
   assign pp = pa * pb;

   always_comb begin
      busy_in = busy_ff; op_in = op_ff; cnt_in = cnt_ff; neg_in = neg_ff;
      acc_in = acc_ff; rem_in = rem_ff; num_in = num_ff;
      ua_in = ua_ff; ub_in = ub_ff; done_in = 1'b0; res_in = res_ff;
      trial = '0; sq_rem = '0; sq_trial = '0; sv = '0;
      if (req.start) begin
         busy_in = 1'b1; op_in = req.op; cnt_in = '0;
         ua_in = abs_a; ub_in = abs_b; acc_in = '0; rem_in = '0;
         case (req.op)
            IT_SQRT: begin
               neg_in = 1'b0;
               num_in = {req.b, 16'h0};
            end
            default: begin
               neg_in = req.a[31] ^ req.b[31];
               num_in = {abs_a, 16'h0};
            end
         endcase
      end else if (busy_ff) begin
         case (op_ff)
            IT_MUL: begin
               acc_in = acc_ff + ({32'h0, pp} <<
                        {({1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]}), 4'h0});
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff == 6'd3) begin
                  busy_in = 1'b0; done_in = 1'b1;
                  if (neg_ff) sv = -$signed({2'b0, acc_in});
                  else sv = $signed({2'b0, acc_in});
                  sv = sv >>> 16;   // floor shift
                  res_in = sat_q(sv);
               end
            end
            IT_DIV: begin
               trial = {rem_ff[62:0], num_ff[47]};
               num_in = {num_ff[46:0], 1'b0};
               if (trial >= {32'h0, ub_ff}) begin
                  rem_in = trial - {32'h0, ub_ff};
                  acc_in = {acc_ff[62:0], 1'b1};
               end else begin
                  rem_in = trial;
                  acc_in = {acc_ff[62:0], 1'b0};
               end
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff == 6'd47) begin
                  busy_in = 1'b0; done_in = 1'b1;
                  if (neg_ff) sv = -$signed({2'b0, acc_in});
                  else sv = $signed({2'b0, acc_in});
                  res_in = sat_q(sv);
               end
            end
            default: begin
               sq_rem = {rem_ff[61:0], num_ff[47:46]};
               num_in = {num_ff[45:0], 2'b0};
               sq_trial = {acc_ff[61:0], 2'b01};
               if (sq_rem >= sq_trial) begin
                  rem_in = sq_rem - sq_trial;
                  acc_in = {acc_ff[62:0], 1'b1};
               end else begin
                  rem_in = sq_rem;
                  acc_in = {acc_ff[62:0], 1'b0};
               end
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff == 6'd23) begin
                  busy_in = 1'b0; done_in = 1'b1;
                  res_in = acc_in[31:0];
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff <= op_in; cnt_ff <= cnt_in; neg_ff <= neg_in;
      acc_ff <= acc_in; rem_ff <= rem_in; num_ff <= num_in;
      ua_ff <= ua_in; ub_ff <= ub_in; res_ff <= res_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;

endmodule

// ===== rtl/stack_machine_executor.sv =====
// Top level of the stack machine executor.
// Executes one decoded instruction per req_ transaction and answers with one
// rsp_ transaction. The data and return stacks live in synchronous memories
// with registered reads. An instruction passes through the states READ and
// EXEC, then ITER while the iterative unit runs mul, div or sqrt, then DONE.
// One instruction is in flight at a time, and a new one is taken as soon as
// the result register is free or being drained.
module stack_machine_executor (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [4:0]   req_func,
   input  logic         req_first_is_register,
   input  logic [1:0]   req_first_register,
   input  logic signed [31:0] req_first_value,
   input  logic         req_second_is_register,
   input  logic [1:0]   req_second_register,
   input  logic signed [31:0] req_second_value,
   input  logic [15:0]  req_jump_target,
   input  logic [15:0]  req_following_address,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic         rsp_redirect,
   output logic [15:0]  rsp_redirect_address,
   output logic         rsp_out_valid,
   output logic signed [31:0] rsp_out_value,
   output logic         rsp_halted,
   output logic [2:0]   rsp_status
);
   import sme_pkg::*;

   state_type state_ff, state_in;

   // latched instruction
   logic [4:0]  func_ff;
   logic        fir_ff, sir_ff;
   logic [1:0]  fr_ff, sr_ff;
   logic [31:0] fv_ff, sv_ff;
   logic [15:0] tgt_ff, fol_ff;

   logic [DataCw-1:0] dcnt_ff, dcnt_in;
   logic [RetCw-1:0]  rcnt_ff, rcnt_in;
   logic [31:0] regs_ff [NumRegs];
   logic [31:0] cmpa_ff, cmpb_ff;
   logic        halt_ff;

   logic [31:0] dmem [DataDepth];
   logic [15:0] rmem [ReturnDepth];
   logic [DataAw-1:0] da_raddr, db_raddr, d_waddr;
   logic [31:0] da_rd_ff, db_rd_ff, d_wdata;
   logic        d_we;
   logic [RetAw-1:0]  r_raddr, r_waddr;
   logic [15:0] r_rd_ff, r_wdata;
   logic        r_we;

   // result register
   logic        rv_ff;
   logic        rredir_ff, rov_ff;
   logic [15:0] raddr_ff;
   logic [31:0] roval_ff;
   logic [2:0]  rstat_ff;

   iter_req_type ireq;
   iter_rsp_type irsp;

   logic accept, exec, fin_iter;
   logic [31:0] a_q, b_q;
   logic signed [32:0] sum;
   logic take;
   logic [DataCw-1:0] dcnt_m1, dcnt_m2;

   sme_iter u_iter (.clock(clock), .reset(reset), .req(ireq), .rsp(irsp));

   assign accept = req_valid && req_ready;
   assign dcnt_m1 = dcnt_ff - DataCw'(1);
   assign dcnt_m2 = dcnt_ff - DataCw'(2);
   assign da_raddr = dcnt_m1[DataAw-1:0];
   assign db_raddr = dcnt_m2[DataAw-1:0];
   assign r_raddr  = rcnt_ff == '0 ? '0 : RetAw'(rcnt_ff - RetCw'(1));

   always_ff @(posedge clock) begin
      if (d_we) dmem[d_waddr] <= d_wdata;
      da_rd_ff <= dmem[da_raddr];
      db_rd_ff <= dmem[db_raddr];
      if (r_we) rmem[r_waddr] <= r_wdata;
      r_rd_ff <= rmem[r_raddr];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) state_in = S_READ;
         S_READ: state_in = S_EXEC;
         S_EXEC: state_in = ireq.start ? S_ITER : S_DONE;
         S_ITER: if (irsp.done) state_in = S_DONE;
         S_DONE: if (!rv_ff || rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign req_ready = state_ff == S_IDLE;
   assign exec = state_ff == S_EXEC;
   assign fin_iter = state_ff == S_ITER && irsp.done;

   function automatic logic [31:0] reg_rd(input logic [1:0] i, input logic [31:0] r [NumRegs]);
      logic [31:0] v;
      v = '0;
      if (32'(i) < NumRegs) v = r[i];
      return v;
   endfunction

   assign a_q = db_rd_ff;
   assign b_q = da_rd_ff;

   always_comb begin
      case (op_type'(func_ff))
         OP_JE:  take = cmpa_ff == cmpb_ff;
         OP_JNE: take = cmpa_ff != cmpb_ff;
         OP_JA:  take = $signed(cmpa_ff) > $signed(cmpb_ff);
         OP_JAE: take = $signed(cmpa_ff) >= $signed(cmpb_ff);
         OP_JB:  take = $signed(cmpa_ff) < $signed(cmpb_ff);
         OP_JBE: take = $signed(cmpa_ff) <= $signed(cmpb_ff);
         default: take = 1'b1;
      endcase
   end

   // result fields computed in EXEC (or at iterative finish)
   logic        n_redir, n_ov, n_upd;
   logic [15:0] n_raddr;
   logic [31:0] n_oval;
   logic [2:0]  n_stat;

   always_comb begin
      n_redir = 1'b0; n_ov = 1'b0; n_raddr = '0; n_oval = '0; n_stat = ST_OK;
      n_upd = 1'b0;
      dcnt_in = dcnt_ff; rcnt_in = rcnt_ff;
      d_we = 1'b0; d_waddr = dcnt_ff[DataAw-1:0]; d_wdata = fv_ff;
      r_we = 1'b0; r_waddr = rcnt_ff[RetAw-1:0]; r_wdata = fol_ff;
      ireq = '{start: 1'b0, op: IT_MUL, a: a_q, b: b_q};
      sum = '0;
      if (fin_iter) begin
         n_upd = 1'b1;
         if (op_type'(func_ff) == OP_SQRT) begin
            d_waddr = da_raddr;
         end else begin
            d_waddr = db_raddr;
            dcnt_in = dcnt_m1;
         end
         d_we = 1'b1; d_wdata = irsp.result;
      end else if (exec && !halt_ff) begin
         n_upd = 1'b1;
         case (func_ff)
            OP_HLT: ;
            OP_PUSHIMM, OP_PUSHREG, OP_IN: begin
               if (32'(dcnt_ff) >= DataDepth) n_stat = ST_DATA_OVF;
               else begin
                  d_we = 1'b1;
                  d_wdata = func_ff == OP_PUSHREG ? reg_rd(fr_ff, regs_ff) : fv_ff;
                  dcnt_in = dcnt_ff + DataCw'(1);
               end
            end
            OP_DROP, OP_POPREG: begin
               if (dcnt_ff == '0) n_stat = ST_UNDERFLOW;
               else dcnt_in = dcnt_m1;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
               if (dcnt_ff < DataCw'(2)) n_stat = ST_UNDERFLOW;
               else if (func_ff == OP_DIV && b_q == '0) n_stat = ST_DIV_ZERO;
               else if (func_ff == OP_ADD || func_ff == OP_SUB) begin
                  sum = func_ff == OP_ADD ? $signed(a_q) + $signed(b_q)
                                          : $signed(a_q) - $signed(b_q);
                  d_we = 1'b1; d_waddr = db_raddr;
                  d_wdata = sat_q(66'(sum));
                  dcnt_in = dcnt_m1;
               end else begin
                  ireq.start = 1'b1;
                  ireq.op = func_ff == OP_MUL ? IT_MUL : IT_DIV;
               end
            end
            OP_SQRT: begin
               if (dcnt_ff == '0) n_stat = ST_UNDERFLOW;
               else if (b_q[31]) n_stat = ST_SQRT_NEG;
               else begin
                  ireq.start = 1'b1; ireq.op = IT_SQRT;
               end
            end
            OP_OUT: begin
               if (dcnt_ff == '0) n_stat = ST_OUT_EMPTY;
               else begin
                  n_ov = 1'b1; n_oval = b_q;
               end
            end
            OP_CMP: ;
            OP_JMP: begin
               n_redir = 1'b1; n_raddr = tgt_ff;
            end
            OP_RET: begin
               if (rcnt_ff != '0) begin
                  rcnt_in = rcnt_ff - RetCw'(1);
                  n_redir = 1'b1; n_raddr = r_rd_ff;
               end
            end
            OP_NOP: ;
            OP_CALL, OP_JE, OP_JNE, OP_JA, OP_JAE, OP_JB, OP_JBE: begin
               if (take) begin
                  if (32'(rcnt_ff) >= ReturnDepth) n_stat = ST_RET_OVF;
                  else begin
                     r_we = 1'b1;
                     rcnt_in = rcnt_ff + RetCw'(1);
                     n_redir = 1'b1; n_raddr = tgt_ff;
                  end
               end
            end
            default: n_stat = ST_ILLEGAL;
         endcase
      end else if (exec) begin
         n_upd = 1'b1;
      end
      if (ireq.start) n_upd = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_func; fir_ff <= req_first_is_register;
         fr_ff <= req_first_register; fv_ff <= req_first_value;
         sir_ff <= req_second_is_register; sr_ff <= req_second_register;
         sv_ff <= req_second_value; tgt_ff <= req_jump_target;
         fol_ff <= req_following_address;
      end
      if (n_upd) begin
         rredir_ff <= n_redir; raddr_ff <= n_raddr;
         rov_ff <= n_ov; roval_ff <= n_oval; rstat_ff <= n_stat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dcnt_ff <= '0; rcnt_ff <= '0;
         cmpa_ff <= '0; cmpb_ff <= '0; halt_ff <= 1'b0;
         rv_ff <= 1'b0;
         for (int i = 0; i < NumRegs; i++) regs_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         dcnt_ff <= dcnt_in; rcnt_ff <= rcnt_in;
         if (exec && !halt_ff) begin
            if (func_ff == OP_HLT) halt_ff <= 1'b1;
            if (func_ff == OP_CMP) begin
               cmpa_ff <= fir_ff ? reg_rd(fr_ff, regs_ff) : fv_ff;
               cmpb_ff <= sir_ff ? reg_rd(sr_ff, regs_ff) : sv_ff;
            end
            if (func_ff == OP_POPREG && dcnt_ff != '0 && 32'(fr_ff) < NumRegs)
               regs_ff[fr_ff] <= b_q;
         end
         if (state_ff == S_DONE && (!rv_ff || rsp_ready)) rv_ff <= 1'b1;
         else if (rsp_ready) rv_ff <= 1'b0;
      end
   end

   // result register holds one transaction; updates only wait in S_DONE
   logic        o_redir_ff, o_ov_ff;
   logic [15:0] o_addr_ff;
   logic [31:0] o_val_ff;
   logic [2:0]  o_stat_ff;
   logic        o_halt_ff;

   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && (!rv_ff || rsp_ready)) begin
         o_redir_ff <= rredir_ff; o_addr_ff <= raddr_ff; o_ov_ff <= rov_ff;
         o_val_ff <= roval_ff; o_stat_ff <= rstat_ff; o_halt_ff <= halt_ff;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_redirect = o_redir_ff;
   assign rsp_redirect_address = o_addr_ff;
   assign rsp_out_valid = o_ov_ff;
   assign rsp_out_value = o_val_ff;
   assign rsp_halted = o_halt_ff;
   assign rsp_status = o_stat_ff;

endmodule

// ===== test/tb_stack_machine_executor.sv =====
// Testbench for stack_machine_executor: directed and random instruction streams against a predictor.
`timescale 1ns / 1ps

module tb_stack_machine_executor;
   import sme_pkg::*;

   localparam int IdleLimit = 2000;
   localparam int HoldCycles = 300;
   localparam logic [4:0] FirstIllegal = 5'd23;
   localparam logic [4:0] LastIllegal = 5'd31;

   typedef struct {
      logic [4:0]         func;
      logic               first_is_register;
      logic [1:0]         first_register;
      logic signed [31:0] first_value;
      logic               second_is_register;
      logic [1:0]         second_register;
      logic signed [31:0] second_value;
      logic [15:0]        jump_target;
      logic [15:0]        following_address;
   } instr_type;

   typedef struct {
      logic        redirect;
      logic [15:0] redirect_address;
      logic        out_valid;
      logic [31:0] out_value;
      logic        halted;
      status_type  status;
   } outcome_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_ready;
   logic [4:0] req_func;
   logic req_first_is_register, req_second_is_register;
   logic [1:0] req_first_register, req_second_register;
   logic signed [31:0] req_first_value, req_second_value;
   logic [15:0] req_jump_target, req_following_address;
   logic rsp_valid, rsp_ready, rsp_redirect, rsp_out_valid, rsp_halted;
   logic [15:0] rsp_redirect_address;
   logic signed [31:0] rsp_out_value;
   logic [2:0] rsp_status;

   stack_machine_executor i_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predicted machine state
   logic signed [31:0] data_mem [DataDepth];
   int                 data_cnt;
   logic [15:0]        ret_mem [ReturnDepth];
   int                 ret_cnt;
   logic signed [31:0] regs [NumRegs];
   logic signed [31:0] cmp_a, cmp_b;
   logic               is_halted;

   outcome_type expected_q[$];
   int errors = 0;
   int burst_left = 0;
   bit gaps_on = 1;
   bit hold_req = 0;

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned root = 0;
      longint unsigned bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= root + bitv) begin
            x -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
      if (v < -64'sh80000000) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic outcome_type execute(instr_type it);
      outcome_type o;
      longint a, b, r;
      bit take;
      o = '{redirect: 0, redirect_address: 0, out_valid: 0, out_value: 0,
            halted: 0, status: ST_OK};
      if (!is_halted) begin
         case (it.func)
            OP_HLT: is_halted = 1;
            OP_PUSHIMM, OP_PUSHREG, OP_IN: begin
               if (data_cnt >= DataDepth) o.status = ST_DATA_OVF;
               else begin
                  data_mem[data_cnt] = (it.func == OP_PUSHREG) ?
                                       regs[it.first_register] : it.first_value;
                  data_cnt++;
               end
            end
            OP_DROP, OP_POPREG: begin
               if (data_cnt == 0) o.status = ST_UNDERFLOW;
               else begin
                  data_cnt--;
                  if (it.func == OP_POPREG) regs[it.first_register] = data_mem[data_cnt];
               end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
               if (data_cnt < 2) o.status = ST_UNDERFLOW;
               else begin
                  b = data_mem[data_cnt-1];
                  a = data_mem[data_cnt-2];
                  if (it.func == OP_DIV && b == 0) o.status = ST_DIV_ZERO;
                  else begin
                     case (it.func)
                        OP_ADD: r = a + b;
                        OP_SUB: r = a - b;
                        OP_MUL: r = (a * b) >>> 16;  // floor
                        default: r = (a * 65536) / b;
                     endcase
                     data_cnt--;
                     data_mem[data_cnt-1] = clamp32(r);
                  end
               end
            end
            OP_SQRT: begin
               if (data_cnt == 0) o.status = ST_UNDERFLOW;
               else if (data_mem[data_cnt-1] < 0) o.status = ST_SQRT_NEG;
               else data_mem[data_cnt-1] =
                       32'(int_sqrt(longint'(data_mem[data_cnt-1]) << 16));
            end
            OP_OUT: begin
               if (data_cnt == 0) o.status = ST_OUT_EMPTY;
               else begin
                  o.out_valid = 1;
                  o.out_value = data_mem[data_cnt-1];
               end
            end
            OP_CMP: begin
               cmp_a = it.first_is_register ? regs[it.first_register] : it.first_value;
               cmp_b = it.second_is_register ? regs[it.second_register] : it.second_value;
            end
            OP_JMP: begin
               o.redirect = 1;
               o.redirect_address = it.jump_target;
            end
            OP_RET: begin
               if (ret_cnt != 0) begin
                  ret_cnt--;
                  o.redirect = 1;
                  o.redirect_address = ret_mem[ret_cnt];
               end
            end
            OP_NOP: ;
            OP_CALL, OP_JE, OP_JNE, OP_JA, OP_JAE, OP_JB, OP_JBE: begin
               case (it.func)
                  OP_JE:   take = (cmp_a == cmp_b);
                  OP_JNE:  take = (cmp_a != cmp_b);
                  OP_JA:   take = (cmp_a > cmp_b);
                  OP_JAE:  take = (cmp_a >= cmp_b);
                  OP_JB:   take = (cmp_a < cmp_b);
                  OP_JBE:  take = (cmp_a <= cmp_b);
                  default: take = 1;
               endcase
               if (take) begin
                  if (ret_cnt >= ReturnDepth) o.status = ST_RET_OVF;
                  else begin
                     ret_mem[ret_cnt] = it.following_address;
                     ret_cnt++;
                     o.redirect = 1;
                     o.redirect_address = it.jump_target;
                  end
               end
            end
            default: o.status = ST_ILLEGAL;
         endcase
      end
      o.halted = is_halted;
      return o;
   endfunction

   function automatic logic signed [31:0] pick_q16();
      case ($urandom_range(0, 7))
         0: return 32'sh0;
         1: return 32'sh7FFFFFFF;
         2: return 32'sh80000000;
         3: return ($signed($urandom_range(0, 20)) - 10) <<< 16;
         4: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
         default: return $urandom;
      endcase
   endfunction

   function automatic instr_type make_instr(logic [4:0] func);
      instr_type it;
      it.func = func;
      it.first_is_register = $urandom_range(0, 1);
      it.first_register = $urandom_range(0, 3);
      it.first_value = pick_q16();
      it.second_is_register = $urandom_range(0, 1);
      it.second_register = $urandom_range(0, 3);
      // equal operands now and then so je/jae/jbe see the equal case
      it.second_value = ($urandom_range(0, 3) == 0) ? it.first_value : pick_q16();
      it.jump_target = $urandom;
      it.following_address = $urandom;
      return it;
   endfunction

   // random instruction, biased toward pushes and returns by the given percentages
   function automatic instr_type random_instr(int push_pct, int ret_pct);
      int r;
      logic [4:0] f;
      r = $urandom_range(0, 99);
      if (r < 3) f = $urandom_range(FirstIllegal, LastIllegal);
      else if (r < 3 + push_pct) begin
         case ($urandom_range(0, 2))
            0: f = OP_PUSHIMM;
            1: f = OP_PUSHREG;
            default: f = OP_IN;
         endcase
      end else if ($urandom_range(0, 99) < ret_pct) f = OP_RET;
      else f = $urandom_range(OP_PUSHIMM, OP_NOP);
      return make_instr(f);
   endfunction

   task automatic send(instr_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0 || !gaps_on) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_func <= it.func;
      req_first_is_register <= it.first_is_register;
      req_first_register <= it.first_register;
      req_first_value <= it.first_value;
      req_second_is_register <= it.second_is_register;
      req_second_register <= it.second_register;
      req_second_value <= it.second_value;
      req_jump_target <= it.jump_target;
      req_following_address <= it.following_address;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_q.push_back(execute(it));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic report(string what, longint got, longint want);
      $display("mismatch: %s got %0h expected %0h", what, got, want);
      errors++;
   endtask

   // result checker and receiver stall pattern
   int rx_mode = 0, rx_cycle = 0, hold_cnt = 0;
   bit hold_seen = 0;
   always @(posedge clock) begin
      outcome_type e;
      if (rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            report("unexpected transaction", 0, 0);
         end else begin
            e = expected_q.pop_front();
            if (rsp_redirect !== e.redirect) report("redirect", rsp_redirect, e.redirect);
            if (rsp_redirect_address !== e.redirect_address)
               report("redirect_address", rsp_redirect_address, e.redirect_address);
            if (rsp_out_valid !== e.out_valid) report("out_valid", rsp_out_valid, e.out_valid);
            if (rsp_out_value !== e.out_value) report("out_value", rsp_out_value, e.out_value);
            if (rsp_halted !== e.halted) report("halted", rsp_halted, e.halted);
            if (rsp_status !== e.status) report("status", rsp_status, e.status);
         end
      end
      if (hold_req && !hold_seen) begin
         hold_seen = 1;
         hold_cnt = HoldCycles;
      end
      if (!hold_req) hold_seen = 0;
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_ready <= 1'b0;
      end else begin
         case (rx_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= $urandom_range(0, 1);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (rx_cycle % 5 != 0);
         endcase
      end
   end

   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
         $display("timeout: no transaction for %0d cycles", IdleLimit);
         $display("tb_stack_machine_executor: FAIL");
         $finish;
      end
   end

   task automatic test_directed();
      instr_type it;
      send(make_instr(OP_RET));    // empty return stack: nothing
      send(make_instr(OP_DROP));
      send(make_instr(OP_OUT));
      send(make_instr(OP_ADD));
      send(make_instr(OP_SQRT));
      it = make_instr(OP_PUSHIMM); it.first_value = 32'sh7FFFFFFF; send(it);
      send(it);
      send(make_instr(OP_ADD));    // saturates high
      send(make_instr(OP_OUT));
      it.first_value = 0; send(it);
      send(make_instr(OP_DIV));    // divide by zero
      send(make_instr(OP_DROP));
      it.first_value = 32'sh80000000; send(it);
      send(make_instr(OP_SQRT));   // negative root
      it.first_value = 32'sh10000; send(it);
      send(make_instr(OP_MUL));
      it = make_instr(OP_POPREG); it.first_register = 3; send(it);
      it.func = OP_PUSHREG; send(it);
      it = make_instr(OP_CMP); it.first_is_register = 1; it.first_register = 3;
      it.second_is_register = 0; send(it);
      send(make_instr(OP_JE));
      send(make_instr(OP_JMP));
      send(make_instr(OP_CALL));
      send(make_instr(OP_RET));
      send(make_instr(LastIllegal));
      send(make_instr(OP_NOP));
   endtask

   // fill both stacks past the top and empty them past the bottom; the receiver holds off as the data stack fill begins
   task automatic test_stack_limits();
      gaps_on = 0;
      hold_req = 1;
      repeat (DataDepth + 2 - data_cnt) send(make_instr(OP_PUSHIMM));
      hold_req = 0;
      repeat (ReturnDepth + 2) send(make_instr(OP_CALL));
      gaps_on = 1;
      wait_drained();
      repeat (DataDepth + 2) send(make_instr(OP_DROP));
      repeat (ReturnDepth + 2) send(make_instr(OP_RET));
   endtask

   task automatic test_random();
      int push_pct, ret_pct;
      for (int blk = 0; blk < 15; blk++) begin
         push_pct = ($urandom_range(0, 2) == 0) ? 70 : $urandom_range(15, 45);
         ret_pct = $urandom_range(5, 40);
         repeat (100) send(random_instr(push_pct, ret_pct));
         if (blk % 6 == 5) wait_drained();
      end
   endtask

   task automatic test_halt();
      send(make_instr(OP_HLT));
      repeat (8) send(random_instr(30, 20));
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_func <= OP_NOP;
      req_first_is_register <= 0;
      req_first_register <= 0;
      req_first_value <= 0;
      req_second_is_register <= 0;
      req_second_register <= 0;
      req_second_value <= 0;
      req_jump_target <= 0;
      req_following_address <= 0;
      rsp_ready <= 1'b0;
      data_cnt = 0;
      ret_cnt = 0;
      foreach (regs[i]) regs[i] = 0;
      cmp_a = 0;
      cmp_b = 0;
      is_halted = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_stack_limits();
      test_random();
      test_halt();
      wait_drained();
      repeat (60) @(posedge clock);
      if (errors == 0) $display("tb_stack_machine_executor: PASS");
      else $display("tb_stack_machine_executor: FAIL");
      $finish;
   end

endmodule
